@@ design/mp2_pkg.sv @@
// ----------------------------------------------------------------------------
// mp2_pkg: shared constants, types and helpers for 2x2 stride-2 max pooling
// Defaults for the size parameters, register codes and position flags.
// ----------------------------------------------------------------------------
`default_nettype none

package mp2_pkg;

  localparam int MAX_FRAME_DEF    = 64;
  localparam int MAX_CHANNELS_DEF = 64;
  localparam int DATA_WIDTH_DEF   = 16;

  // configuration port
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_SIZE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'd1;

  localparam int FRAME_SIZE_RST    = 32;
  localparam int CHANNEL_COUNT_RST = 6;

  // result queue depth
  localparam int OUT_FIFO_DEPTH = 4;

  // role of the beat being taken in
  typedef struct packed {
    logic in_win;   // inside the even part of the map
    logic col_odd;  // second column of a pair
    logic row_odd;  // second row of a pair
    logic last;     // last pooled element of the map
  } pos_flags_t;

  function automatic int clamp(input int v, input int lo, input int hi);
    int res;
    res = v;
    if (res < lo) res = lo;
    if (res > hi) res = hi;
    return res;
  endfunction

endpackage

`default_nettype wire

@@ design/mp2_pix_if.sv @@
// ----------------------------------------------------------------------------
// mp2_pix_if: input element channel
// valid/ready handshake carrying one map element per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mp2_pix_if #(
  parameter int DATA_WIDTH = mp2_pkg::DATA_WIDTH_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] pixel_value;
  logic                         frame_start;

  modport source (output valid, output pixel_value, output frame_start, input ready);
  modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

`default_nettype wire

@@ design/mp2_pool_if.sv @@
// ----------------------------------------------------------------------------
// mp2_pool_if: pooled result channel
// valid/ready handshake carrying one window maximum per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mp2_pool_if #(
  parameter int DATA_WIDTH = mp2_pkg::DATA_WIDTH_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] pooled_value;
  logic                         frame_last;

  modport source (output valid, output pooled_value, output frame_last, input ready);
  modport sink   (input valid, input pooled_value, input frame_last, output ready);
endinterface

`default_nettype wire

@@ design/mp2_pos_ctr.sv @@
// ----------------------------------------------------------------------------
// mp2_pos_ctr: row / column / channel position of the incoming beat
// Gives store addresses and role flags, steps on each accepted beat.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2_pos_ctr #(
  parameter int MAX_FRAME    = mp2_pkg::MAX_FRAME_DEF,
  parameter int MAX_CHANNELS = mp2_pkg::MAX_CHANNELS_DEF,
  localparam int RC_W        = $clog2(MAX_FRAME),
  localparam int CH_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int FS_W        = $clog2(MAX_FRAME + 1),
  localparam int CC_W        = $clog2(MAX_CHANNELS + 1),
  localparam int STORE_DEPTH = (MAX_FRAME / 2) * MAX_CHANNELS,
  localparam int SLOT_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire logic                frame_start,
  input  wire logic [FS_W-1:0]     fs_act,
  input  wire logic [CC_W-1:0]     cc_act,
  output      logic [CH_W-1:0]     ch,
  output      logic [SLOT_W-1:0]   slot,
  output      mp2_pkg::pos_flags_t flags
);

  logic [RC_W-1:0] row_r, row_nxt, row_cur;
  logic [RC_W-1:0] col_r, col_nxt, col_cur;
  logic [CH_W-1:0] ch_r, ch_nxt, ch_cur;
  logic [FS_W-1:0] even_fs;
  logic [FS_W-1:0] row_w, col_w;
  logic [CC_W-1:0] ch_inc;

  // frame_start restarts the map at this very beat
  assign row_cur = frame_start ? '0 : row_r;
  assign col_cur = frame_start ? '0 : col_r;
  assign ch_cur  = frame_start ? '0 : ch_r;

  assign even_fs = fs_act & ~FS_W'(1);

  assign ch   = ch_cur;
  assign slot = SLOT_W'(int'(col_cur >> 1) * MAX_CHANNELS + int'(ch_cur));

  always_comb begin
    flags.in_win  = (FS_W'(row_cur) < even_fs) && (FS_W'(col_cur) < even_fs);
    flags.col_odd = col_cur[0];
    flags.row_odd = row_cur[0];
    flags.last    = (FS_W'(row_cur) == even_fs - FS_W'(1))
                 && (FS_W'(col_cur) == even_fs - FS_W'(1))
                 && (CC_W'(ch_cur) == cc_act - CC_W'(1));
  end

  // next position; each counter wraps once it reaches or passes its bound
  always_comb begin
    ch_inc = CC_W'(ch_cur) + CC_W'(1);
    row_w  = FS_W'(row_cur);
    col_w  = FS_W'(col_cur);
    ch_nxt = CH_W'(ch_inc);
    if (ch_inc >= cc_act) begin
      ch_nxt = '0;
      col_w  = FS_W'(col_cur) + FS_W'(1);
      if (col_w >= fs_act) begin
        col_w = '0;
        row_w = FS_W'(row_cur) + FS_W'(1);
        if (row_w >= fs_act) row_w = '0;
      end
    end
    if (col_w >= fs_act) col_w = '0;
    if (row_w >= fs_act) row_w = '0;
    row_nxt = RC_W'(row_w);
    col_nxt = RC_W'(col_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      ch_r  <= '0;
    end else if (step) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      ch_r  <= ch_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/mp2_pool_core.sv @@
// ----------------------------------------------------------------------------
// mp2_pool_core: pair and line stores with read-modify-write datapath
// Reads both stores on accept, compares and writes back in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2_pool_core #(
  parameter int MAX_FRAME    = mp2_pkg::MAX_FRAME_DEF,
  parameter int MAX_CHANNELS = mp2_pkg::MAX_CHANNELS_DEF,
  parameter int DATA_WIDTH   = mp2_pkg::DATA_WIDTH_DEF,
  localparam int CH_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int STORE_DEPTH = (MAX_FRAME / 2) * MAX_CHANNELS,
  localparam int SLOT_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         acc,
  input  wire logic signed [DATA_WIDTH-1:0] pix,
  input  wire logic [CH_W-1:0]              ch,
  input  wire logic [SLOT_W-1:0]            slot,
  input  wire mp2_pkg::pos_flags_t          flags,
  output      logic                         res_valid,
  output      logic signed [DATA_WIDTH-1:0] res_value,
  output      logic                         res_last
);

  logic signed [DATA_WIDTH-1:0] pair_mem [MAX_CHANNELS];
  logic signed [DATA_WIDTH-1:0] row_mem  [STORE_DEPTH];

  logic signed [DATA_WIDTH-1:0] pair_rd_r, row_rd_r;
  logic signed [DATA_WIDTH-1:0] s1_pix_r, byp_r;
  logic [CH_W-1:0]              s1_ch_r;
  logic [SLOT_W-1:0]            s1_slot_r;
  mp2_pkg::pos_flags_t          s1_flags_r;
  logic                         s1_valid_r, byp_sel_r;

  logic                         pair_we, row_we;
  logic signed [DATA_WIDTH-1:0] pair_val, hmax, vmax;

  assign pair_we = s1_valid_r && s1_flags_r.in_win && !s1_flags_r.col_odd;
  assign row_we  = s1_valid_r && s1_flags_r.in_win && s1_flags_r.col_odd
                && !s1_flags_r.row_odd;

  // with one channel the even column is written while the odd one reads it
  assign pair_val = byp_sel_r ? byp_r : pair_rd_r;
  assign hmax     = (s1_pix_r > pair_val) ? s1_pix_r : pair_val;
  assign vmax     = (row_rd_r > hmax) ? row_rd_r : hmax;

  assign res_valid = s1_valid_r && s1_flags_r.in_win && s1_flags_r.col_odd
                  && s1_flags_r.row_odd;
  assign res_value = vmax;
  assign res_last  = s1_flags_r.last;

  // store reads, registered
  always_ff @(posedge clk) begin
    if (acc) begin
      pair_rd_r <= pair_mem[ch];
      row_rd_r  <= row_mem[slot];
    end
  end

  // write-back; no beat needs a line slot read that the beat before it writes
  always_ff @(posedge clk) begin
    if (pair_we) pair_mem[s1_ch_r] <= s1_pix_r;
    if (row_we)  row_mem[s1_slot_r] <= hmax;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r   <= pix;
      s1_ch_r    <= ch;
      s1_slot_r  <= slot;
      s1_flags_r <= flags;
      byp_sel_r  <= pair_we && (s1_ch_r == ch);
      byp_r      <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= acc;
  end

endmodule

`default_nettype wire

@@ design/mp2_out_fifo.sv @@
// ----------------------------------------------------------------------------
// mp2_out_fifo: small result queue in front of the output channel
// Decouples result delivery from the input side.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2_out_fifo #(
  parameter int DATA_WIDTH = mp2_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH      = mp2_pkg::OUT_FIFO_DEPTH,
  localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  input  wire logic signed [DATA_WIDTH-1:0] push_value,
  input  wire logic                         push_last,
  input  wire logic                         pop_ready,
  output      logic                         pop_valid,
  output      logic signed [DATA_WIDTH-1:0] pop_value,
  output      logic                         pop_last,
  output      logic [CNT_W-1:0]             count
);

  logic signed [DATA_WIDTH-1:0] val_q [DEPTH];
  logic                         last_q [DEPTH];
  logic [PTR_W-1:0]             wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic                         pop;

  assign pop_valid = (count_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_value = val_q[rd_ptr_r];
  assign pop_last  = last_q[rd_ptr_r];
  assign count     = count_r;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop)      count_nxt = count_r + CNT_W'(1);
    else if (!push && pop) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      val_q[wr_ptr_r]  <= push_value;
      last_q[wr_ptr_r] <= push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (int'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= (int'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + PTR_W'(1);
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/max_pool_2x2_stride2.sv @@
// Throughput: 1 element beat per cycle while the result queue has room, set by the
//   single read and write port of each store; the result queue keeps input flowing
//   while a result waits to be taken; results pass the compare stage, then the queue.
// Reset (synchronous, rst_n low): position counters to row 0, column 0, channel 0,
//   frame_size to 32, channel_count to 6, pipeline and result queue emptied.
//   Pair and line stores are not cleared; no clearing pass is run.
// ----------------------------------------------------------------------------
// max_pool_2x2_stride2: streaming 2x2 max pooling with stride 2
// Per-channel even-column element store, line store of even-row pair maxima.
// ----------------------------------------------------------------------------
`default_nettype none

module max_pool_2x2_stride2 #(
  parameter int MAX_FRAME    = mp2_pkg::MAX_FRAME_DEF,
  parameter int MAX_CHANNELS = mp2_pkg::MAX_CHANNELS_DEF,
  parameter int DATA_WIDTH   = mp2_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  mp2_pix_if.sink                              in_pix,
  mp2_pool_if.source                           out_pool,
  input  wire logic                            cfg_we,
  input  wire logic [mp2_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mp2_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int CH_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int FS_W        = $clog2(MAX_FRAME + 1);
  localparam int CC_W        = $clog2(MAX_CHANNELS + 1);
  localparam int STORE_DEPTH = (MAX_FRAME / 2) * MAX_CHANNELS;
  localparam int SLOT_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int FIFO_DEPTH  = mp2_pkg::OUT_FIFO_DEPTH;
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

  localparam logic [FS_W-1:0] FS_RST =
    FS_W'(mp2_pkg::clamp(mp2_pkg::FRAME_SIZE_RST, 2, MAX_FRAME));
  localparam logic [CC_W-1:0] CC_RST =
    CC_W'(mp2_pkg::clamp(mp2_pkg::CHANNEL_COUNT_RST, 1, MAX_CHANNELS));

  // Registers are held already saturated to their usable range.
  logic [FS_W-1:0] fs_act_r;
  logic [CC_W-1:0] cc_act_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_act_r <= FS_RST;
      cc_act_r <= CC_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mp2_pkg::REG_FRAME_SIZE: begin
          fs_act_r <= FS_W'(mp2_pkg::clamp(int'(cfg_wdata), 2, MAX_FRAME));
        end
        mp2_pkg::REG_CHANNEL_COUNT: begin
          cc_act_r <= CC_W'(mp2_pkg::clamp(int'(cfg_wdata), 1, MAX_CHANNELS));
        end
        default: begin
        end
      endcase
    end
  end

  // Input beat taken only when the queue can absorb the result still in
  // the compare stage plus one from this beat.
  logic                         in_acc;
  logic [CNT_W-1:0]             fifo_count;
  logic                         res_valid, res_last;
  logic signed [DATA_WIDTH-1:0] res_value;

  assign in_pix.ready = (int'(fifo_count) + int'(res_valid)) < FIFO_DEPTH;
  assign in_acc       = in_pix.valid && in_pix.ready;

  // position of the beat being taken
  logic [CH_W-1:0]     pos_ch;
  logic [SLOT_W-1:0]   pos_slot;
  mp2_pkg::pos_flags_t pos_flags;

  mp2_pos_ctr #(
    .MAX_FRAME    (MAX_FRAME),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_acc),
    .frame_start (in_pix.frame_start),
    .fs_act      (fs_act_r),
    .cc_act      (cc_act_r),
    .ch          (pos_ch),
    .slot        (pos_slot),
    .flags       (pos_flags)
  );

  // Stores: read on accept, compare and write back in the next cycle.
  mp2_pool_core #(
    .MAX_FRAME    (MAX_FRAME),
    .MAX_CHANNELS (MAX_CHANNELS),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .pix       (in_pix.pixel_value),
    .ch        (pos_ch),
    .slot      (pos_slot),
    .flags     (pos_flags),
    .res_valid (res_valid),
    .res_value (res_value),
    .res_last  (res_last)
  );

  // result queue drives the output channel
  mp2_out_fifo #(
    .DATA_WIDTH (DATA_WIDTH),
    .DEPTH      (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_value (res_value),
    .push_last  (res_last),
    .pop_ready  (out_pool.ready),
    .pop_valid  (out_pool.valid),
    .pop_value  (out_pool.pooled_value),
    .pop_last   (out_pool.frame_last),
    .count      (fifo_count)
  );

  // Back-pressure on the input only ever comes from results queued up.
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_pix.ready |-> out_pool.valid)
    else $error("input stalled with no result waiting");

  // A window result follows a beat in the odd row and odd column of a window.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> $past(in_acc && pos_flags.in_win && pos_flags.col_odd
                        && pos_flags.row_odd))
    else $error("window result without closing beat");

  // The queue is never pushed when full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (int'(fifo_count) < FIFO_DEPTH))
    else $error("result queue overflow");

endmodule

`default_nettype wire

@@ sim/mp2_pool_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2_pool_checker: window maximum predictor and result comparator
// Watches both channels and the register port, predicts each pooled beat
// and compares the results in order.
// ----------------------------------------------------------------------------

module mp2_pool_checker #(
  parameter int MAX_FRAME    = mp2_pkg::MAX_FRAME_DEF,
  parameter int MAX_CHANNELS = mp2_pkg::MAX_CHANNELS_DEF,
  parameter int DATA_WIDTH   = mp2_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mp2_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mp2_pkg::CFG_W-1:0]     cfg_wdata,
  mp2_pix_if                            pix,
  mp2_pool_if                           pool,
  output int                            error_count,
  output int                            pending
);
  import mp2_pkg::*;

  localparam int LINE_DEPTH = (MAX_FRAME / 2) * MAX_CHANNELS;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         last;
  } window_result_t;

  logic signed [DATA_WIDTH-1:0] col_pair_max [MAX_CHANNELS];
  logic signed [DATA_WIDTH-1:0] even_row_max [LINE_DEPTH];
  logic [CFG_W-1:0]             frame_reg;
  logic [CFG_W-1:0]             chan_reg;
  int unsigned                  row_at, col_at, ch_at;
  window_result_t               windows_due [$];
  window_result_t               want;
  int                           faults = 0;

  // one element in: update the pair and line stores, queue a window max
  // when the element closes a window
  task automatic take_element(input logic signed [DATA_WIDTH-1:0] v, input logic restart);
    int unsigned fs, cc, efs, slot;
    logic signed [DATA_WIDTH-1:0] m;
    window_result_t res;
    fs = (frame_reg < 2) ? 2 : (frame_reg > MAX_FRAME) ? MAX_FRAME : int'(frame_reg);
    cc = (chan_reg < 1) ? 1 : (chan_reg > MAX_CHANNELS) ? MAX_CHANNELS : int'(chan_reg);
    efs = fs & ~32'd1;
    if (restart) begin
      row_at = 0;
      col_at = 0;
      ch_at  = 0;
    end
    if (row_at < efs && col_at < efs) begin
      if ((col_at & 1) == 0) begin
        col_pair_max[ch_at] = v;
      end else begin
        m = (v > col_pair_max[ch_at]) ? v : col_pair_max[ch_at];
        slot = (col_at >> 1) * MAX_CHANNELS + ch_at;
        if ((row_at & 1) == 0) begin
          even_row_max[slot] = m;
        end else begin
          res.value = (m > even_row_max[slot]) ? m : even_row_max[slot];
          res.last  = (row_at == efs - 1) && (col_at == efs - 1) && (ch_at == cc - 1);
          windows_due.push_back(res);
        end
      end
    end
    // counters step; any one past a shrunken bound wraps at once
    ch_at++;
    if (ch_at >= cc) begin
      ch_at = 0;
      col_at++;
      if (col_at >= fs) begin
        col_at = 0;
        row_at++;
        if (row_at >= fs) row_at = 0;
      end
    end
    if (col_at >= fs) col_at = 0;
    if (row_at >= fs) row_at = 0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      frame_reg = CFG_W'(FRAME_SIZE_RST);
      chan_reg  = CFG_W'(CHANNEL_COUNT_RST);
      row_at = 0;
      col_at = 0;
      ch_at  = 0;
      windows_due.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_FRAME_SIZE) frame_reg = cfg_wdata;
        else if (cfg_index == REG_CHANNEL_COUNT) chan_reg = cfg_wdata;
      end
      if (pix.valid && pix.ready) take_element(pix.pixel_value, pix.frame_start);
      if (pool.valid && pool.ready) begin
        if (windows_due.size() == 0) begin
          faults++;
          $display("%0t ns: result beat with none due: expected nothing, got %0d last %0b",
                   $time, $signed(pool.pooled_value), pool.frame_last);
        end else begin
          want = windows_due.pop_front();
          if (pool.pooled_value !== want.value) begin
            faults++;
            $display("%0t ns: pooled_value expected %0d, got %0d",
                     $time, $signed(want.value), $signed(pool.pooled_value));
          end
          if (pool.frame_last !== want.last) begin
            faults++;
            $display("%0t ns: frame_last expected %0b, got %0b",
                     $time, want.last, pool.frame_last);
          end
        end
      end
      pending <= windows_due.size();
    end
    error_count <= faults;
  end

endmodule

@@ sim/tb_max_pool_2x2_stride2.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_pool_2x2_stride2: stimulus and verdict for the 2x2 stride-2 pooler
// Directed maps at the smallest and odd sizes, then random phases of sizes and
// element streams with random gaps and stalls; a checker alongside the
// block predicts and compares every result beat.
// ----------------------------------------------------------------------------

module tb_max_pool_2x2_stride2;
  import mp2_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int MAX_FR      = MAX_FRAME_DEF;
  localparam int MAX_CH      = MAX_CHANNELS_DEF;
  localparam int LINE_DEPTH  = (MAX_FR / 2) * MAX_CH;
  localparam int RUN_ITEMS   = 1850;
  // slowest run: every beat with the longest sender gap plus the longest result stall,
  // with a drain per phase; this limit is several times that
  localparam int CYCLE_LIMIT = 500000;

  localparam logic signed [15:0] PIX_MAX = 16'h7FFF;
  localparam logic signed [15:0] PIX_MIN = 16'h8000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   error_count;
  int                   pending;
  int unsigned          cycle_count = 0;
  int unsigned          elements_sent = 0;
  bit                   send_quiet = 1'b0;
  bit                   take_quiet = 1'b0;

  // Shadow of where the block is in the map, and which store entries have
  // been filled since reset. The block's stores hold junk until written, so
  // an element that would read an unfilled entry is turned into a map start.
  int unsigned      pos_row = 0, pos_col = 0, pos_ch = 0;
  logic [CFG_W-1:0] trk_frame = CFG_W'(FRAME_SIZE_RST);
  logic [CFG_W-1:0] trk_chans = CFG_W'(CHANNEL_COUNT_RST);
  bit               pair_filled [MAX_CH];
  bit               line_filled [LINE_DEPTH];

  mp2_pix_if  pix ();
  mp2_pool_if pool ();

  max_pool_2x2_stride2 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (pix),
    .out_pool  (pool),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  mp2_pool_checker pool_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .pix         (pix),
    .pool        (pool),
    .error_count (error_count),
    .pending     (pending)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_max_pool_2x2_stride2: errors");
      $finish;
    end
  end

  // register value as the block uses it, saturated to its bounds
  function automatic int unsigned bounded(input logic [CFG_W-1:0] raw,
                                          input int unsigned lo, input int unsigned hi);
    if (raw < lo) return lo;
    if (raw > hi) return hi;
    return int'(raw);
  endfunction

  // random register value: mostly small, some mid, the top size, and some
  // out of range on either side
  function automatic logic [CFG_W-1:0] draw_reg(input int unsigned lo);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return CFG_W'($urandom_range(lo, 8));
    if (sel < 75) return CFG_W'($urandom_range(9, 20));
    if (sel < 85) return CFG_W'(64);
    if (sel < 92) return CFG_W'($urandom_range(0, lo - 1));
    return CFG_W'($urandom_range(65, 127));
  endfunction

  // advance the shadow position by one element; forces a map start where
  // the element would otherwise pick up an unfilled store entry
  task automatic place_element(inout bit restart);
    int unsigned fs, cc, efs, slot;
    fs  = bounded(trk_frame, 2, MAX_FR);
    cc  = bounded(trk_chans, 1, MAX_CH);
    efs = fs & ~32'd1;
    if (!restart && pos_row < efs && pos_col < efs && (pos_col & 1) == 1) begin
      slot = (pos_col >> 1) * MAX_CH + pos_ch;
      if (!pair_filled[pos_ch] || ((pos_row & 1) == 1 && !line_filled[slot]))
        restart = 1'b1;
    end
    if (restart) begin
      pos_row = 0;
      pos_col = 0;
      pos_ch  = 0;
    end
    if (pos_row < efs && pos_col < efs) begin
      slot = (pos_col >> 1) * MAX_CH + pos_ch;
      if ((pos_col & 1) == 0) pair_filled[pos_ch] = 1'b1;
      else if ((pos_row & 1) == 0) line_filled[slot] = 1'b1;
    end
    pos_ch++;
    if (pos_ch >= cc) begin
      pos_ch = 0;
      pos_col++;
      if (pos_col >= fs) begin
        pos_col = 0;
        pos_row++;
        if (pos_row >= fs) pos_row = 0;
      end
    end
    if (pos_col >= fs) pos_col = 0;
    if (pos_row >= fs) pos_row = 0;
  endtask

  // one element beat; valid is only dropped when a gap is drawn, so
  // back-to-back beats never lower and raise it in the same step
  task automatic send_element(input logic signed [15:0] value, input bit start);
    int unsigned gap;
    bit          restart;
    restart = start;
    place_element(restart);
    if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid       <= 1'b1;
    pix.pixel_value <= value;
    pix.frame_start <= restart;
    do @(posedge clk); while (!pix.ready);
    elements_sent++;
  endtask

  // stop sending and let every due result out; the extra cycles cover
  // elements that make no result but are still in the pipeline
  task automatic wait_idle();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register writes, only ever issued with the block idle;
  // fields: 0 both registers, 1 frame size only, 2 channel count only
  task automatic set_sizes(input logic [CFG_W-1:0] frame, input logic [CFG_W-1:0] chans,
                           input int unsigned fields);
    if (fields != 2) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_FRAME_SIZE;
      cfg_wdata <= frame;
      @(posedge clk);
      trk_frame = frame;
    end
    if (fields != 1) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_CHANNEL_COUNT;
      cfg_wdata <= chans;
      @(posedge clk);
      trk_chans = chans;
    end
    cfg_we <= 1'b0;
  endtask

  // result side: random stall before each beat, with quiet stretches
  initial begin : result_sink
    int unsigned stall;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) take_quiet = !take_quiet;
      stall = take_quiet ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        pool.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pool.ready <= 1'b1;
      do @(posedge clk); while (!pool.valid);
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0]   frame, chans;
    logic signed [15:0] value;
    int unsigned        per_map, count;
    bit                 start;

    pix.valid       = 1'b0;
    pix.pixel_value = '0;
    pix.frame_start = 1'b0;
    pool.ready      = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_FRAME_SIZE;
    cfg_wdata       = '0;
    rst_n           = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // smallest map, one channel: one window per map
    set_sizes(CFG_W'(2), CFG_W'(1), 0);
    send_element(PIX_MAX, 1'b1);
    send_element(PIX_MIN, 1'b0);
    send_element(PIX_MIN, 1'b0);
    send_element(PIX_MIN, 1'b0);
    // map wraps with no start flag; all-minimum window
    send_element(PIX_MIN, 1'b0);
    send_element(PIX_MIN, 1'b0);
    send_element(PIX_MIN, 1'b0);
    send_element(PIX_MIN, 1'b0);
    // all negative, maximum in the lower right corner
    send_element(-16'sd5, 1'b0);
    send_element(-16'sd3, 1'b0);
    send_element(-16'sd4, 1'b0);
    send_element(-16'sd1, 1'b0);
    wait_idle();

    // odd size: third row and column are taken and thrown away
    set_sizes(CFG_W'(3), CFG_W'(1), 0);
    send_element(16'sd10, 1'b1);
    send_element(-16'sd20, 1'b0);
    send_element(16'sd30000, 1'b0);
    send_element(-16'sd7, 1'b0);
    send_element(16'sd11, 1'b0);
    send_element(PIX_MAX, 1'b0);
    send_element(PIX_MAX, 1'b0);
    send_element(PIX_MAX, 1'b0);
    send_element(PIX_MAX, 1'b0);
    wait_idle();

    // registers below range saturate to 2 and 1
    set_sizes(CFG_W'(0), CFG_W'(0), 0);
    send_element(16'sd1, 1'b1);
    send_element(16'sd2, 1'b0);
    send_element(16'sd3, 1'b0);
    send_element(16'sd4, 1'b0);

    // --- random phases ---
    // each phase drains, changes one or both registers and streams
    // elements; phases may stop mid-map so the next sizes take over there
    while (elements_sent < 25 + RUN_ITEMS) begin
      wait_idle();
      frame = draw_reg(2);
      chans = draw_reg(1);
      set_sizes(frame, chans, $urandom_range(0, 3) % 3);
      per_map = bounded(trk_frame, 2, MAX_FR) * bounded(trk_frame, 2, MAX_FR)
                * bounded(trk_chans, 1, MAX_CH);
      count = (per_map <= 130) ? per_map * $urandom_range(1, 2) : 0;
      if (count == 0 || $urandom_range(0, 3) == 0) count += $urandom_range(1, 130);
      if (count > 260) count = 260;
      repeat (count) begin
        case ($urandom_range(0, 9))
          0:       value = PIX_MIN;
          1:       value = PIX_MAX;
          2:       value = $urandom_range(0, 1) ? 16'sd0 : -16'sd1;
          default: value = 16'($urandom_range(0, 65535));
        endcase
        // at a map boundary, half the maps start by flag and half by wrap;
        // elsewhere a rare stray start cuts the map short
        if (pos_row == 0 && pos_col == 0 && pos_ch == 0)
          start = bit'($urandom_range(0, 1));
        else
          start = ($urandom_range(0, 99) < 3);
        send_element(value, start);
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (error_count == 0)
      $display("tb_max_pool_2x2_stride2: clean");
    else
      $display("tb_max_pool_2x2_stride2: errors");
    $finish;
  end

endmodule
